// ===== hw/rtl/rset_pkg.sv =====
// shared types and constants for the randomized set table
// payload structs, control/status structs, operation and status codes, fsm states
`timescale 1ns / 1ps

package rset_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W        = 32;
	localparam int RND_W        = 31;
	localparam int DIV_CNT_W    = $clog2(RND_W);

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_PICK   = 2'd2;

	localparam logic [2:0] STAT_DONE    = 3'd0;
	localparam logic [2:0] STAT_PRESENT = 3'd1;
	localparam logic [2:0] STAT_ABSENT  = 3'd2;
	localparam logic [2:0] STAT_FULL    = 3'd3;
	localparam logic [2:0] STAT_EMPTY   = 3'd4;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [KEY_W-1:0] key;
		logic [RND_W-1:0]        random_word;
	} in_t;

	typedef struct packed {
		logic                    success;
		logic signed [KEY_W-1:0] picked_value;
		logic [2:0]              status;
	} out_t;

	typedef enum logic [0:0] {
		RD_LAST,
		RD_REM
	} rd_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SEARCH,
		S_LAST_RD,
		S_LAST_WR,
		S_DIV,
		S_PICK_RD,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic       ld;
		logic       srch_run;
		logic       div_run;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       wr_ins;
		logic       wr_mov;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_set;
		logic       res_success;
		logic [2:0] res_status;
		logic       res_pick;
		logic       out_push;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       cnt_zero;
		logic       full;
		logic       hit;
		logic       srch_end;
		logic       div_last;
		logic       out_free;
	} sts_t;

endpackage

// ===== hw/rtl/rset_ctrl.sv =====
// controller state machine for the randomized set table
// sequences search, divide, slot moves and result beats; uses rset_pkg
`timescale 1ns / 1ps

module rset_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rset_pkg::sts_t sts,
	output rset_pkg::cmd_t cmd
);
	import rset_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.ld  = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.mode)
					MODE_INSERT, MODE_REMOVE: begin
						state_d = S_SEARCH;
					end
					MODE_PICK: begin
						if (sts.cnt_zero) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = STAT_EMPTY;
							state_d        = S_FINISH;
						end else begin
							state_d = S_DIV;
						end
					end
					default: begin
						cmd.res_set    = 1'b1;
						cmd.res_status = STAT_DONE;
						state_d        = S_FINISH;
					end
				endcase
			end
			S_SEARCH: begin
				cmd.srch_run = 1'b1;
				if (sts.hit) begin
					if (sts.mode == MODE_INSERT) begin
						cmd.res_set    = 1'b1;
						cmd.res_status = STAT_PRESENT;
						state_d        = S_FINISH;
					end else begin
						state_d = S_LAST_RD;
					end
				end else if (sts.srch_end) begin
					cmd.res_set = 1'b1;
					state_d     = S_FINISH;
					if (sts.mode == MODE_INSERT) begin
						if (sts.full) begin
							cmd.res_status = STAT_FULL;
						end else begin
							cmd.wr_ins      = 1'b1;
							cmd.cnt_inc     = 1'b1;
							cmd.res_success = 1'b1;
							cmd.res_status  = STAT_DONE;
						end
					end else begin
						cmd.res_status = STAT_ABSENT;
					end
				end
			end
			S_LAST_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_LAST;
				state_d    = S_LAST_WR;
			end
			S_LAST_WR: begin
				// last slot value fills the hole left by the removed key
				cmd.wr_mov      = 1'b1;
				cmd.cnt_dec     = 1'b1;
				cmd.res_set     = 1'b1;
				cmd.res_success = 1'b1;
				cmd.res_status  = STAT_DONE;
				state_d         = S_FINISH;
			end
			S_DIV: begin
				cmd.div_run = 1'b1;
				if (sts.div_last) begin
					state_d = S_PICK_RD;
				end
			end
			S_PICK_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RD_REM;
				state_d     = S_FINISH;
				// picked value is captured in the finish step below
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// pick result is not staged through res_set; it is taken from the slot read at the push
		if (state_q == S_FINISH && sts.mode == MODE_PICK && !sts.cnt_zero && !cmd.out_push) begin
			cmd.res_set = 1'b0;
		end
	end

endmodule

// ===== hw/rtl/rset_dp.sv =====
// datapath for the randomized set table
// slot memory, element count, linear search, restoring divider, result registers; uses rset_pkg
`timescale 1ns / 1ps

module rset_dp #(
	parameter int CAPACITY = rset_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rset_pkg::in_t  req,
	input  rset_pkg::cmd_t cmd,
	output rset_pkg::sts_t sts,
	input  logic           rsp_ready,
	output logic           rsp_valid,
	output rset_pkg::out_t rsp
);
	import rset_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [KEY_W-1:0]     mem [CAPACITY];
	logic [KEY_W-1:0]     rdata_q;
	logic [KEY_W-1:0]     key_q;
	logic [1:0]           mode_q;
	logic                 pick_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        cnt_m1;
	logic [CW-1:0]        srch_idx_q;
	logic                 cmp_vld_s1;
	logic [AW-1:0]        cmp_idx_s1;
	logic [AW-1:0]        pos_q;
	logic [CW-1:0]        rem_q;
	logic [RND_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [CW:0]          trial;
	logic [CW:0]          diff;
	logic                 srch_issue;
	logic                 hit;
	logic                 rd_fire;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [KEY_W-1:0]     wr_data;
	out_t                 res_q;
	out_t                 out_q;
	logic                 rsp_valid_q;

	assign cnt_m1     = cnt_q - CW'(1);
	assign srch_issue = srch_idx_q < cnt_q;
	assign hit        = cmp_vld_s1 && (rdata_q == key_q);
	assign rd_fire    = cmd.rd_en | (cmd.srch_run & srch_issue);

	always_comb begin
		if (cmd.srch_run) begin
			rd_addr = srch_idx_q[AW-1:0];
		end else if (cmd.rd_sel == RD_LAST) begin
			rd_addr = cnt_m1[AW-1:0];
		end else begin
			rd_addr = rem_q[AW-1:0];
		end
	end

	assign wr_en   = cmd.wr_ins | cmd.wr_mov;
	assign wr_addr = cmd.wr_ins ? cnt_q[AW-1:0] : pos_q;
	assign wr_data = cmd.wr_ins ? key_q : rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_fire) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// element count and search index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			srch_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.ld) begin
				srch_idx_q <= '0;
				cmp_vld_s1 <= 1'b0;
			end else if (cmd.srch_run) begin
				cmp_vld_s1 <= srch_issue;
				if (srch_issue) begin
					srch_idx_q <= srch_idx_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			key_q  <= req.key;
			mode_q <= req.mode;
		end
		if (cmd.srch_run) begin
			cmp_idx_s1 <= srch_idx_q[AW-1:0];
			if (hit) begin
				pos_q <= cmp_idx_s1;
			end
		end
	end

	// restoring divide of the random word by the count, keeping only the remainder, one dividend bit a cycle
	assign trial = {rem_q, quo_q[RND_W-1]};
	assign diff  = trial - {1'b0, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.ld) begin
			div_cnt_q <= '0;
		end else if (cmd.div_run) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			rem_q <= '0;
			quo_q <= req.random_word;
		end else if (cmd.div_run) begin
			quo_q <= {quo_q[RND_W-2:0], 1'b0};
			if (trial >= {1'b0, cnt_q}) begin
				rem_q <= diff[CW-1:0];
			end else begin
				rem_q <= trial[CW-1:0];
			end
		end
	end

	// result staging and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_q <= 1'b0;
		end else if (cmd.ld) begin
			pick_q <= 1'b0;
		end else if (cmd.rd_en && cmd.rd_sel == RD_REM) begin
			pick_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_q.success      <= cmd.res_success;
			res_q.status       <= cmd.res_status;
			res_q.picked_value <= cmd.res_pick ? signed'(rdata_q) : '0;
		end
		if (cmd.out_push) begin
			if (pick_q) begin
				out_q.success      <= 1'b1;
				out_q.status       <= STAT_DONE;
				out_q.picked_value <= signed'(rdata_q);
			end else begin
				out_q <= res_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = out_q;

	assign sts.mode     = mode_q;
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.full     = (cnt_q == CW'(CAPACITY));
	assign sts.hit      = hit;
	assign sts.srch_end = !srch_issue && !cmp_vld_s1;
	assign sts.div_last = (div_cnt_q == DIV_CNT_W'(RND_W - 1));
	assign sts.out_free = !rsp_valid_q || rsp_ready;

endmodule

// ===== hw/rtl/randomized_set_table.sv =====
// top level of the randomized set table
// joins rset_ctrl and rset_dp; uses rset_pkg
`timescale 1ns / 1ps

// Set of up to CAPACITY distinct signed 32-bit keys kept densely in a single-port-read
// slot memory with an element count. One request beat carries insert, remove or pick and
// gives exactly one response beat. Insert and remove scan the occupied slots one per cycle;
// remove then moves the last slot into the hole. Pick reduces random_word modulo the count
// with a bit-serial divider and then reads one slot. One request is worked on at a time;
// the next request is taken while the previous response still waits in the output register.
// Slot contents are not cleared at reset; only occupied slots are ever read.
module randomized_set_table #(
	parameter int CAPACITY = rset_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rset_pkg::in_t  req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rset_pkg::out_t rsp
);
	import rset_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rset_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rset_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while previous one is in progress");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_ins |-> (!sts.full && !sts.hit))
		else $error("insert write into a full store or with key present");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_push |-> sts.out_free)
		else $error("response beat overwrites one not yet taken");

	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> !sts.cnt_zero)
		else $error("count decrement on empty set");

endmodule
